/* sv/q24alu_pkg.sv */
// ----------------------------------------------------------------------------
// q24alu_pkg
// Shared opcodes, status codes, pipeline payload type and helpers for the
// Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
package q24alu_pkg;

    typedef enum logic [4:0] {
        FN_ADD        = 5'd0,
        FN_SUB        = 5'd1,
        FN_MUL        = 5'd2,
        FN_DIV        = 5'd3,
        FN_GT         = 5'd4,
        FN_LT         = 5'd5,
        FN_GE         = 5'd6,
        FN_LE         = 5'd7,
        FN_EQ         = 5'd8,
        FN_NE         = 5'd9,
        FN_MIN        = 5'd10,
        FN_MAX        = 5'd11,
        FN_INC        = 5'd12,
        FN_DEC        = 5'd13,
        FN_TO_INT     = 5'd14,
        FN_TO_FLOAT   = 5'd15,
        FN_FROM_INT   = 5'd16,
        FN_FROM_FLOAT = 5'd17
    } func_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVF     = 2'd1;
    localparam logic [1:0] ST_DIV0    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] MAX_NEG = 32'h8000_0000;

    // Payload that travels down the pipeline with each beat
    typedef struct packed {
        func_t       func;
        logic [31:0] res;
        logic        flag;
        logic [1:0]  st;
        logic        neg;
        logic        b_zero;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
    } alu_pipe_t;

    typedef struct packed {
        logic [31:0] res;
        logic        ovf;
    } fit_t;

    // Apply a sign to a magnitude and flag when it leaves signed 32 bits
    function automatic fit_t fit32(input logic [63:0] mag, input logic neg);
        fit_t f;
        f.ovf = neg ? (mag > 64'(MAX_NEG)) : (mag > 64'(MAX_POS));
        f.res = neg ? (~mag[31:0] + 32'd1) : mag[31:0];
        return f;
    endfunction

endpackage

/* sv/q24alu_if.sv */
// ----------------------------------------------------------------------------
// q24alu channel interfaces
// Valid/ready channels for the ALU command and response beats.
// ----------------------------------------------------------------------------
interface q24alu_cmd_if;
    logic        valid;
    logic        ready;
    logic [4:0]  func;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic [31:0] float_bits;

    modport source (output valid, func, operand_a, operand_b, float_bits, input ready);
    modport sink   (input valid, func, operand_a, operand_b, float_bits, output ready);
endinterface

interface q24alu_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] result;
    logic        flag_true;
    logic [1:0]  status;

    modport source (output valid, result, flag_true, status, input ready);
    modport sink   (input valid, result, flag_true, status, output ready);
endinterface

/* sv/q24alu_front.sv */
// ----------------------------------------------------------------------------
// q24alu_front
// First stage: decode, the operations that finish here and operand magnitudes.
// ----------------------------------------------------------------------------
module q24alu_front
    import q24alu_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        v_in,
    input  logic [4:0]  func,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  logic [31:0] float_bits,
    output logic        valid_reg,
    output alu_pipe_t   pipe_reg
);

    alu_pipe_t   pipe_next;
    logic [32:0] sum;
    logic [32:0] diff;
    logic [32:0] inc;
    logic [32:0] dec;
    logic        lt;
    logic        eq;
    logic [32:0] trunc;
    logic [FRAC_BITS:0] hi;

    always_comb
    begin
        sum   = {operand_a[31], operand_a} + {operand_b[31], operand_b};
        diff  = {operand_a[31], operand_a} - {operand_b[31], operand_b};
        inc   = {operand_a[31], operand_a} + 33'd1;
        dec   = {operand_a[31], operand_a} - 33'd1;
        lt    = $signed(operand_a) < $signed(operand_b);
        eq    = operand_a == operand_b;
        // bias negatives so the arithmetic shift truncates toward zero
        trunc = $signed({operand_a[31], operand_a}
                + (operand_a[31] ? 33'((34'd1 << FRAC_BITS) - 34'd1) : 33'd0)) >>> FRAC_BITS;
        hi    = operand_a[31 -: FRAC_BITS + 1];

        pipe_next        = '0;
        pipe_next.func   = func_t'(func);
        pipe_next.st     = ST_OK;
        pipe_next.b_zero = operand_b == 32'd0;
        pipe_next.mag_a  = operand_a[31] ? (~operand_a + 32'd1) : operand_a;
        pipe_next.mag_b  = operand_b[31] ? (~operand_b + 32'd1) : operand_b;
        pipe_next.neg    = operand_a[31] ^ operand_b[31];

        case (func)
            FN_ADD:
            begin
                pipe_next.res = sum[31:0];
                pipe_next.st  = (sum[32] != sum[31]) ? ST_OVF : ST_OK;
            end
            FN_SUB:
            begin
                pipe_next.res = diff[31:0];
                pipe_next.st  = (diff[32] != diff[31]) ? ST_OVF : ST_OK;
            end
            FN_MUL, FN_DIV:
            begin
                pipe_next.res = '0;
            end
            FN_GT:  pipe_next.flag = !lt && !eq;
            FN_LT:  pipe_next.flag = lt;
            FN_GE:  pipe_next.flag = !lt;
            FN_LE:  pipe_next.flag = lt || eq;
            FN_EQ:  pipe_next.flag = eq;
            FN_NE:  pipe_next.flag = !eq;
            FN_MIN: pipe_next.res  = lt ? operand_a : operand_b;
            FN_MAX: pipe_next.res  = (!lt && !eq) ? operand_a : operand_b;
            FN_INC:
            begin
                pipe_next.res = inc[31:0];
                pipe_next.st  = (inc[32] != inc[31]) ? ST_OVF : ST_OK;
            end
            FN_DEC:
            begin
                pipe_next.res = dec[31:0];
                pipe_next.st  = (dec[32] != dec[31]) ? ST_OVF : ST_OK;
            end
            FN_TO_INT: pipe_next.res = trunc[31:0];
            FN_TO_FLOAT:
            begin
                pipe_next.neg = operand_a[31];
            end
            FN_FROM_INT:
            begin
                pipe_next.res = operand_a << FRAC_BITS;
                pipe_next.st  = (&hi || !(|hi)) ? ST_OK : ST_OVF;
            end
            FN_FROM_FLOAT:
            begin
                // carry the raw float pattern in the magnitude slot
                pipe_next.mag_a = float_bits;
                pipe_next.neg   = float_bits[31];
            end
            default: pipe_next.st = ST_INVALID;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg <= pipe_next;
        end
    end

endmodule

/* sv/q24alu_conv.sv */
// ----------------------------------------------------------------------------
// q24alu_conv
// Three stages for multiply and the float conversions: product / leading one
// / float decode, then shift, then round and saturate.
// ----------------------------------------------------------------------------
module q24alu_conv
    import q24alu_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      v_in,
    input  alu_pipe_t pipe_in,
    output logic      valid_reg,
    output alu_pipe_t pipe_reg
);

    // stage 2
    logic        v2_reg;
    alu_pipe_t   p2_reg;
    logic [63:0] prod_reg;
    logic [4:0]  msb_reg;
    logic        nan2_reg;
    logic        inf2_reg;
    logic        zero2_reg;
    logic        sat2_reg;
    logic        tiny2_reg;
    logic [9:0]  sh_reg;
    logic [23:0] sig_reg;

    // stage 3
    logic        v3_reg;
    alu_pipe_t   p3_reg;
    logic [31:0] norm_reg;
    logic [4:0]  msb3_reg;
    logic [31:0] t_reg;
    logic        rnd_reg;
    logic        nan3_reg;
    logic        inf3_reg;
    logic        zero3_reg;
    logic        sat3_reg;
    logic        tiny3_reg;

    logic [4:0]  msb_next;
    logic [9:0]  sh_next;
    logic [7:0]  fexp;
    alu_pipe_t   p3_next;
    fit_t        mul_fit;
    logic [31:0] t_next;
    logic [9:0]  nsh;
    logic [4:0]  rshift;
    alu_pipe_t   p4_next;
    logic [24:0] m25;
    logic [23:0] mant;
    logic [5:0]  pexp;
    logic [8:0]  bexp;
    logic        rup;
    logic [32:0] fmag;

    // stage 2 combinational
    always_comb
    begin
        msb_next = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (pipe_in.mag_a[i])
            begin
                msb_next = 5'(i);
            end
        end
        fexp    = pipe_in.mag_a[30:23];
        sh_next = 10'(fexp) - 10'd150 + 10'(FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_reg    <= pipe_in;
            prod_reg  <= 64'(pipe_in.mag_a) * 64'(pipe_in.mag_b);
            msb_reg   <= msb_next;
            nan2_reg  <= (fexp == 8'hFF) && (pipe_in.mag_a[22:0] != 23'd0);
            inf2_reg  <= (fexp == 8'hFF) && (pipe_in.mag_a[22:0] == 23'd0);
            zero2_reg <= fexp == 8'd0;
            sat2_reg  <= !sh_next[9] && (sh_next > 10'd8);
            tiny2_reg <= sh_next[9] && ($signed(sh_next) < -10'sd25);
            sh_reg    <= sh_next;
            sig_reg   <= {1'b1, pipe_in.mag_a[22:0]};
        end
    end

    // stage 3 combinational: finish multiply, align for both conversions
    always_comb
    begin
        mul_fit = fit32(p2_reg.func == FN_MUL ? (prod_reg >> FRAC_BITS) : 64'd0, p2_reg.neg);
        p3_next = p2_reg;
        if (p2_reg.func == FN_MUL)
        begin
            p3_next.res = mul_fit.res;
            p3_next.st  = mul_fit.ovf ? ST_OVF : ST_OK;
        end
        nsh    = 10'd0 - sh_reg;
        rshift = nsh[4:0] - 5'd1;
        if (!sh_reg[9])
        begin
            t_next = 32'(sig_reg) << sh_reg[3:0];
        end
        else
        begin
            t_next = 32'(sig_reg >> rshift);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_reg    <= p3_next;
            norm_reg  <= p2_reg.mag_a << (5'd31 - msb_reg);
            msb3_reg  <= msb_reg;
            t_reg     <= t_next;
            rnd_reg   <= sh_reg[9];
            nan3_reg  <= nan2_reg;
            inf3_reg  <= inf2_reg;
            zero3_reg <= zero2_reg;
            sat3_reg  <= sat2_reg;
            tiny3_reg <= tiny2_reg;
        end
    end

    // stage 4 combinational: round to single, round and saturate to fixed
    always_comb
    begin
        rup  = norm_reg[7] && ((|norm_reg[6:0]) || norm_reg[8]);
        m25  = {1'b0, norm_reg[31:8]} + 25'(rup);
        mant = m25[24] ? m25[24:1] : m25[23:0];
        pexp = 6'(msb3_reg) + 6'(m25[24]);
        bexp = 9'(pexp) + 9'd127 - 9'(FRAC_BITS);
        fmag = rnd_reg ? ((33'(t_reg) + 33'd1) >> 1) : 33'(t_reg);

        p4_next = p3_reg;
        if (p3_reg.func == FN_TO_FLOAT)
        begin
            if (p3_reg.mag_a == 32'd0)
            begin
                p4_next.res = '0;
            end
            else
            begin
                p4_next.res = {p3_reg.neg, bexp[7:0], mant[22:0]};
            end
        end
        else if (p3_reg.func == FN_FROM_FLOAT)
        begin
            p4_next.res = '0;
            p4_next.st  = ST_OK;
            if (nan3_reg)
            begin
                p4_next.st = ST_INVALID;
            end
            else if (inf3_reg || (!zero3_reg && sat3_reg))
            begin
                p4_next.st  = ST_OVF;
                p4_next.res = p3_reg.neg ? MAX_NEG : MAX_POS;
            end
            else if (zero3_reg || tiny3_reg)
            begin
                p4_next.res = '0;
            end
            else if (!p3_reg.neg && (fmag > 33'(MAX_POS)))
            begin
                p4_next.st  = ST_OVF;
                p4_next.res = MAX_POS;
            end
            else if (p3_reg.neg && (fmag > 33'(MAX_NEG)))
            begin
                p4_next.st  = ST_OVF;
                p4_next.res = MAX_NEG;
            end
            else
            begin
                p4_next.res = p3_reg.neg ? (~fmag[31:0] + 32'd1) : fmag[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg <= p4_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg    <= v_in;
            v3_reg    <= v2_reg;
            valid_reg <= v3_reg;
        end
    end

endmodule

/* sv/q24alu_div_step.sv */
// ----------------------------------------------------------------------------
// q24alu_div_step
// One restoring-division stage: develops one quotient bit per beat.
// ----------------------------------------------------------------------------
module q24alu_div_step
    import q24alu_pkg::*;
#(
    parameter int NUM_W = 40
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             v_in,
    input  alu_pipe_t        pipe_in,
    input  logic [31:0]      rem_in,
    input  logic [NUM_W-1:0] num_in,
    output logic             valid_reg,
    output alu_pipe_t        pipe_reg,
    output logic [31:0]      rem_reg,
    output logic [NUM_W-1:0] num_reg
);

    logic [32:0] trial;
    logic [32:0] sub;
    logic        qbit;

    always_comb
    begin
        trial = {rem_in, num_in[NUM_W-1]};
        sub   = trial - 33'(pipe_in.mag_b);
        qbit  = trial >= 33'(pipe_in.mag_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg <= pipe_in;
            rem_reg  <= qbit ? sub[31:0] : trial[31:0];
            num_reg  <= {num_in[NUM_W-2:0], qbit};
        end
    end

endmodule

/* sv/q24alu_back.sv */
// ----------------------------------------------------------------------------
// q24alu_back
// Last stage: signs and range-checks the quotient and holds the response.
// ----------------------------------------------------------------------------
module q24alu_back
    import q24alu_pkg::*;
#(
    parameter int NUM_W = 40
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             v_in,
    input  alu_pipe_t        pipe_in,
    input  logic [NUM_W-1:0] quot,
    output logic             valid_reg,
    output logic [31:0]      result_reg,
    output logic             flag_reg,
    output logic [1:0]       status_reg
);

    fit_t        qfit;
    logic [31:0] result_next;
    logic [1:0]  status_next;

    always_comb
    begin
        qfit        = fit32(64'(quot), pipe_in.neg);
        result_next = pipe_in.res;
        status_next = pipe_in.st;
        if (pipe_in.func == FN_DIV)
        begin
            if (pipe_in.b_zero)
            begin
                result_next = '0;
                status_next = ST_DIV0;
            end
            else
            begin
                result_next = qfit.res;
                status_next = qfit.ovf ? ST_OVF : ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
            flag_reg   <= pipe_in.flag;
            status_reg <= status_next;
        end
    end

endmodule

/* sv/fixed_point_q24_8_alu.sv */
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Pipelined Q24.8 fixed-point ALU with float conversions.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one operation per beat: opcode, two raw fixed operands and a
//   single-precision pattern. rsp returns one beat per command, in order,
//   with the result, the comparison flag and a status code.
//   Throughput is one command per cycle while rsp does not stall. The
//   pipeline holds one decode stage, three multiply/convert stages,
//   32 + FRAC_BITS restoring-divider stages (one quotient bit each), and
//   the response register. The divider chain sets the depth.
//   All stages advance together; when rsp stalls with a beat held, cmd.ready
//   drops and every stage holds. An empty response register never blocks.
//   Reset clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu
    import q24alu_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic clk,
    input  logic rst_n,
    q24alu_cmd_if.sink   cmd,
    q24alu_rsp_if.source rsp
);

    localparam int NUM_W = 32 + FRAC_BITS;

    logic      adv;
    logic      v1;
    alu_pipe_t p1;
    logic      v4;
    alu_pipe_t p4;

    logic             dv   [NUM_W+1];
    alu_pipe_t        dp   [NUM_W+1];
    logic [31:0]      drem [NUM_W+1];
    logic [NUM_W-1:0] dnum [NUM_W+1];

    logic        rsp_valid;
    logic [31:0] rsp_result;

    assign adv       = !rsp_valid || rsp.ready;
    assign cmd.ready = adv;

    q24alu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .v_in       (cmd.valid),
        .func       (cmd.func),
        .operand_a  (cmd.operand_a),
        .operand_b  (cmd.operand_b),
        .float_bits (cmd.float_bits),
        .valid_reg  (v1),
        .pipe_reg   (p1)
    );

    q24alu_conv #(.FRAC_BITS(FRAC_BITS)) u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .v_in      (v1),
        .pipe_in   (p1),
        .valid_reg (v4),
        .pipe_reg  (p4)
    );

    assign dv[0]   = v4;
    assign dp[0]   = p4;
    assign drem[0] = '0;
    assign dnum[0] = {p4.mag_a, {FRAC_BITS{1'b0}}};

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_div
        q24alu_div_step #(.NUM_W(NUM_W)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .v_in      (dv[i]),
            .pipe_in   (dp[i]),
            .rem_in    (drem[i]),
            .num_in    (dnum[i]),
            .valid_reg (dv[i+1]),
            .pipe_reg  (dp[i+1]),
            .rem_reg   (drem[i+1]),
            .num_reg   (dnum[i+1])
        );
    end

    q24alu_back #(.NUM_W(NUM_W)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .v_in       (dv[NUM_W]),
        .pipe_in    (dp[NUM_W]),
        .quot       (dnum[NUM_W]),
        .valid_reg  (rsp_valid),
        .result_reg (rsp_result),
        .flag_reg   (rsp.flag_true),
        .status_reg (rsp.status)
    );

    assign rsp.valid  = rsp_valid;
    assign rsp.result = rsp_result;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Q24.8 fixed-point ALU. Commands go in on the
// cmd channel and each response is compared against a golden model of the
// arithmetic, the comparisons and the float conversions, in order, under
// several patterns of source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import q24alu_pkg::*;

    localparam int FRAC = 8;
    localparam int PIPE_DEPTH = FRAC + 37;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [31:0] result;
        logic        flag;
        logic [1:0]  status;
    } alu_rsp_t;

    logic clk;
    logic rst_n;

    q24alu_cmd_if cmd ();
    q24alu_rsp_if rsp ();

    fixed_point_q24_8_alu #(.FRAC_BITS(FRAC)) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .rsp  (rsp)
    );

    alu_rsp_t rsp_fifo[$];
    int       src_idle_pct;
    int       sink_stall_pct;
    int       hold_reqs;
    int       hold_seen;
    int       hold_left;
    int       n_sent;
    int       n_checked;
    int       n_errors;
    int       quiet_cycles;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Golden model
    // ------------------------------------------------------------------
    function automatic logic [63:0] abs64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [31:0] wrap32(input longint v, inout logic [1:0] st);
        if (v > 64'sd2147483647 || v < -64'sd2147483648)
            st = ST_OVF;
        return v[31:0];
    endfunction

    function automatic logic [31:0] signed_mag(input logic [63:0] m, input logic neg,
                                              inout logic [1:0] st);
        if ((neg && m > 64'h8000_0000) || (!neg && m > 64'h7FFF_FFFF))
            st = ST_OVF;
        return neg ? 32'(-m) : m[31:0];
    endfunction

    function automatic logic [31:0] fixed_to_single(input longint v);
        logic [63:0] m, mant, rem, half;
        int          p, sh;
        if (v == 0)
            return 32'd0;
        m = abs64(v);
        p = 31;
        while (p > 0 && m[p] == 1'b0)
            p--;
        if (p <= 23)
        begin
            mant = m << (23 - p);
        end
        else
        begin
            sh   = p - 23;
            rem  = m & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            mant = m >> sh;
            if (rem > half || (rem == half && mant[0]))
                mant++;
            if (mant == (64'd1 << 24))
            begin
                mant = mant >> 1;
                p++;
            end
        end
        return {(v < 0), 8'(p + 127 - FRAC), mant[22:0]};
    endfunction

    function automatic logic [31:0] single_to_fixed(input logic [31:0] fb,
                                                   inout logic [1:0] st);
        logic        neg;
        int          e, sh;
        logic [63:0] sig, m;
        neg = fb[31];
        e   = int'(fb[30:23]);
        if (e == 255)
        begin
            if (fb[22:0] != 23'd0)
            begin
                st = ST_INVALID;
                return 32'd0;
            end
            st = ST_OVF;
            return neg ? MAX_NEG : MAX_POS;
        end
        if (e == 0)
            return 32'd0;
        sig = {41'd1, fb[22:0]};
        sh  = e - 150 + FRAC;
        if (sh > 8)
        begin
            st = ST_OVF;
            return neg ? MAX_NEG : MAX_POS;
        end
        if (sh >= 0)
            m = sig << sh;
        else if (-sh > 25)
            m = '0;
        else
            m = (sig + (64'd1 << (-sh - 1))) >> (-sh);
        if (!neg && m > 64'h7FFF_FFFF)
        begin
            st = ST_OVF;
            return MAX_POS;
        end
        if (neg && m > 64'h8000_0000)
        begin
            st = ST_OVF;
            return MAX_NEG;
        end
        return neg ? 32'(-m) : m[31:0];
    endfunction

    function automatic alu_rsp_t alu_golden(input logic [4:0] fn, input logic [31:0] ra,
                                            input logic [31:0] rb, input logic [31:0] fb);
        alu_rsp_t r;
        longint   a, b;
        logic     neg;
        a   = longint'($signed(ra));
        b   = longint'($signed(rb));
        neg = (a < 0) != (b < 0);
        r   = '0;
        case (fn)
            FN_ADD:        r.result = wrap32(a + b, r.status);
            FN_SUB:        r.result = wrap32(a - b, r.status);
            FN_MUL:        r.result = signed_mag((abs64(a) * abs64(b)) >> FRAC, neg, r.status);
            FN_DIV:
                if (b == 0)
                    r.status = ST_DIV0;
                else
                    r.result = signed_mag((abs64(a) << FRAC) / abs64(b), neg, r.status);
            FN_GT:         r.flag = a > b;
            FN_LT:         r.flag = a < b;
            FN_GE:         r.flag = a >= b;
            FN_LE:         r.flag = a <= b;
            FN_EQ:         r.flag = a == b;
            FN_NE:         r.flag = a != b;
            FN_MIN:        r.result = (a < b) ? ra : rb;
            FN_MAX:        r.result = (a > b) ? ra : rb;
            FN_INC:        r.result = wrap32(a + 1, r.status);
            FN_DEC:        r.result = wrap32(a - 1, r.status);
            FN_TO_INT:     r.result = 32'(a / (64'sd1 << FRAC));
            FN_TO_FLOAT:   r.result = fixed_to_single(a);
            FN_FROM_INT:   r.result = wrap32(a * (64'sd1 << FRAC), r.status);
            FN_FROM_FLOAT: r.result = single_to_fixed(fb, r.status);
            default:       r.status = ST_INVALID;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command source
    // ------------------------------------------------------------------
    task automatic send_op(input logic [4:0] fn, input logic [31:0] a,
                           input logic [31:0] b, input logic [31:0] fb);
        cmd.func       <= fn;
        cmd.operand_a  <= a;
        cmd.operand_b  <= b;
        cmd.float_bits <= fb;
        cmd.valid      <= 1'b1;
        do
            @(posedge clk);
        while (!cmd.ready);
        rsp_fifo.push_back(alu_golden(fn, a, b, fb));
        n_sent++;
        // idle after the beat, drop valid once for the whole gap
        if ($urandom_range(99) < src_idle_pct)
        begin
            cmd.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (rsp_fifo.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(9))
            0:       return MAX_POS;
            1:       return MAX_NEG;
            2:       return 32'($signed($urandom_range(512)) - 256);
            3:       return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
            4:       return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_single();
        logic [7:0] e;
        case ($urandom_range(7))
            0:       e = 8'd0;
            1:       e = 8'd255;
            2:       return $urandom;
            default: e = 8'($urandom_range(110, 153));
        endcase
        return {1'($urandom), e, 23'($urandom_range(3) == 0 ? 0 : $urandom)};
    endfunction

    task automatic send_random();
        logic [4:0] fn;
        logic [31:0] a, b;
        fn = ($urandom_range(49) == 0) ? 5'($urandom_range(18, 31))
                                       : 5'($urandom_range(FN_FROM_FLOAT));
        a  = rand_operand();
        b  = ($urandom_range(7) == 0) ? a : rand_operand();
        if (fn == FN_DIV && $urandom_range(15) == 0)
            b = 32'd0;
        send_op(fn, a, b, rand_single());
    endtask

    // ------------------------------------------------------------------
    // Response sink, checker and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        alu_rsp_t want;
        if (!rst_n)
        begin
            rsp.ready    <= 1'b0;
            hold_left    <= 0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (rsp_fifo.size() == 0)
                begin
                    $error("unexpected response beat: result %h", rsp.result);
                    n_errors++;
                end
                else
                begin
                    want = rsp_fifo.pop_front();
                    n_checked++;
                    if (rsp.result !== want.result)
                    begin
                        $error("result: expected %h actual %h", want.result, rsp.result);
                        n_errors++;
                    end
                    if (rsp.flag_true !== want.flag)
                    begin
                        $error("flag_true: expected %b actual %b", want.flag, rsp.flag_true);
                        n_errors++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d actual %0d", want.status, rsp.status);
                        n_errors++;
                    end
                end
            end
            // hold off the sink on request, else stall at random
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left <= HOLD_CYCLES;
                rsp.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
            if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_op(FN_ADD, MAX_POS, 32'd1, 0);
        send_op(FN_ADD, MAX_NEG, MAX_NEG, 0);
        send_op(FN_SUB, MAX_NEG, 32'd1, 0);
        send_op(FN_MUL, MAX_POS, MAX_POS, 0);
        send_op(FN_MUL, MAX_NEG, 32'h0000_0100, 0);
        send_op(FN_MUL, 32'hFFFF_FF80, 32'h0000_0080, 0);
        send_op(FN_DIV, 32'h0000_0300, 32'd0, 0);
        send_op(FN_DIV, MAX_NEG, 32'hFFFF_FF00, 0);
        send_op(FN_DIV, MAX_POS, 32'd1, 0);
        send_op(FN_GT, MAX_NEG, MAX_POS, 0);
        send_op(FN_LT, MAX_NEG, MAX_POS, 0);
        send_op(FN_GE, 32'd5, 32'd5, 0);
        send_op(FN_LE, MAX_POS, MAX_NEG, 0);
        send_op(FN_EQ, MAX_NEG, MAX_NEG, 0);
        send_op(FN_NE, 32'd0, 32'd0, 0);
        send_op(FN_MIN, MAX_POS, MAX_NEG, 0);
        send_op(FN_MAX, MAX_POS, MAX_NEG, 0);
        send_op(FN_INC, MAX_POS, 0, 0);
        send_op(FN_DEC, MAX_NEG, 0, 0);
        send_op(FN_TO_INT, 32'hFFFF_FE80, 0, 0);
        send_op(FN_TO_FLOAT, MAX_NEG, 0, 0);
        send_op(FN_TO_FLOAT, MAX_POS, 0, 0);
        send_op(FN_FROM_INT, 32'h0080_0000, 0, 0);
        send_op(FN_FROM_FLOAT, 0, 0, 32'h7FC0_0001);
        send_op(FN_FROM_FLOAT, 0, 0, 32'hFF80_0000);
        send_op(FN_FROM_FLOAT, 0, 0, 32'h0000_0001);
        send_op(FN_FROM_FLOAT, 0, 0, 32'hCF00_0000);
        send_op(5'd31, MAX_POS, MAX_NEG, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_random(input int n, input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (n)
            send_random();
        drain();
    endtask

    // fill the pipe while the sink is held off, then wait for it to empty
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_reqs++;
        repeat (120)
            send_random();
        drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cmd.valid      = 1'b0;
        cmd.func       = '0;
        cmd.operand_a  = '0;
        cmd.operand_b  = '0;
        cmd.float_bits = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_reqs      = 0;
        hold_seen      = 0;
        n_sent         = 0;
        n_checked      = 0;
        n_errors       = 0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(230, 0, 0);
        test_random(230, 76, 0);
        test_random(230, 0, 76);
        test_random(230, 17, 17);
        test_backpressure();

        repeat (PIPE_DEPTH + 10)
            @(posedge clk);
        $display("ran %0d ALU ops (all opcodes, float specials, overflow, div by zero)",
                 n_sent);
        $display("checked %0d responses under idle, stall and hold-off patterns", n_checked);
        if (n_errors == 0 && rsp_fifo.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
